@@ rtl/cdtb_pkg.sv @@
package cdtb_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W = 5;
	localparam int MASK_W = 32;
	localparam int ENABLE_BIT = 31;
	localparam int EXPIRED_BIT = 0;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [1:0] FIELD_CONTROL = 2'd0;
	localparam logic [1:0] FIELD_LOAD = 2'd1;
	localparam logic [1:0] FIELD_COUNT = 2'd2;
	localparam logic [1:0] FIELD_STATUS = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [IDX_W-1:0] timer_index;
		logic [1:0] field_select;
		logic [WORD_W-1:0] write_value;
	} cdtb_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [MASK_W-1:0] expired_mask;
	} cdtb_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESP
	} cdtb_state_t;

	typedef struct packed {
		logic hit;
		logic bus_we;
		logic bus_re;
		logic sweep_re;
		logic resp;
	} cdtb_ctl_t;

endpackage

@@ rtl/cdtb_word_ram.sv @@
module cdtb_word_ram import cdtb_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;

	// per-entry valid bits stand in for a reset of the array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/cdtb_tick_unit.sv @@
module cdtb_tick_unit import cdtb_pkg::*; #(
	parameter int NUM_TIMERS = 32,
	parameter int COUNT_WIDTH = 32,
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cdtb_ctl_t              ctl,
	input  logic [AW-1:0]          addr,
	input  cdtb_cmd_t              cmd_q,
	output logic [COUNT_WIDTH-1:0] count_rd,
	output logic [NUM_TIMERS-1:0]  expired
);

	logic [NUM_TIMERS-1:0]  en_q;
	logic [NUM_TIMERS-1:0]  exp_q;
	logic                   vld_s1;
	logic [AW-1:0]          idx_s1;
	logic                   dec_go;
	logic [COUNT_WIDTH-1:0] dec_val;
	logic                   bus_cnt_we;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	// shared decrement and zero test, one timer per cycle during a sweep
	assign dec_go = vld_s1 && en_q[idx_s1] && (count_rd != '0);
	assign dec_val = count_rd - COUNT_WIDTH'(1);

	assign bus_cnt_we = ctl.bus_we && (cmd_q.field_select == FIELD_COUNT);
	assign ram_we = bus_cnt_we || dec_go;
	assign ram_waddr = dec_go ? idx_s1 : addr;
	assign ram_wdata = dec_go ? dec_val : cmd_q.write_value[COUNT_WIDTH-1:0];

	cdtb_word_ram #(
		.DEPTH(NUM_TIMERS),
		.WIDTH(COUNT_WIDTH)
	) u_count_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.bus_re || ctl.sweep_re),
		.raddr (addr),
		.rdata (count_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.sweep_re;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			exp_q <= '0;
		end else begin
			if (ctl.bus_we && (cmd_q.field_select == FIELD_CONTROL)) begin
				en_q[addr] <= cmd_q.write_value[ENABLE_BIT];
			end
			if (ctl.bus_we && (cmd_q.field_select == FIELD_STATUS)) begin
				exp_q[addr] <= cmd_q.write_value[EXPIRED_BIT];
			end
			if (dec_go && (dec_val == '0)) begin
				exp_q[idx_s1] <= 1'b1;
			end
		end
	end

	assign expired = exp_q;

endmodule

@@ rtl/cdtb_seq.sv @@
module cdtb_seq import cdtb_pkg::*; #(
	parameter int NUM_TIMERS = 32,
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cdtb_cmd_t     cmd,
	output logic          busy,
	output cdtb_ctl_t     ctl,
	output cdtb_cmd_t     cmd_q,
	output logic [AW-1:0] addr
);

	localparam logic [AW-1:0] LAST = AW'(NUM_TIMERS - 1);

	cdtb_state_t   state_q;
	cdtb_state_t   state_d;
	logic [AW-1:0] ptr_q;
	cdtb_cmd_t     cmd_r_q;
	logic          hit;

	assign hit = 32'(cmd_r_q.timer_index) < 32'(NUM_TIMERS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = (cmd_r_q.mode == MODE_TICK) ? ST_SWEEP : ST_RESP;
			end
			ST_SWEEP: begin
				if (ptr_q == LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.hit = hit;
		busy = (state_q != ST_IDLE);
		addr = AW'(cmd_r_q.timer_index);
		case (state_q)
			ST_EXEC: begin
				ctl.bus_we = hit && (cmd_r_q.mode == MODE_WRITE);
				ctl.bus_re = hit && (cmd_r_q.mode == MODE_READ);
			end
			ST_SWEEP: begin
				ctl.sweep_re = 1'b1;
				addr = ptr_q;
			end
			ST_RESP: begin
				ctl.resp = 1'b1;
			end
			default: begin
				ctl.resp = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				ptr_q <= '0;
			end else if ((state_q == ST_SWEEP) && (ptr_q != LAST)) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_r_q <= cmd;
		end
	end

	assign cmd_q = cmd_r_q;

endmodule

@@ rtl/countdown_timer_bank_top.sv @@
// Bank of NUM_TIMERS countdown timers, each with control, load, count and status
// words. An item is taken when start is high and busy is low; its one result
// appears on rsp for exactly one cycle with done high, and must be captured
// then, since there is no way to hold it. done comes in the cycle in which the
// next item can first be accepted. A tick sweeps the count memory through its
// one read port and one write port with one shared decrementer, one timer per
// cycle. All words read as zero after reset with no clearing pass. read_value
// is zero except on a read of an existing timer; expired_mask shows status
// bit 0 of timers 0 to MASK_W-1, with zero for bits past NUM_TIMERS.
module countdown_timer_bank_top import cdtb_pkg::*; #(
	parameter int NUM_TIMERS = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cdtb_cmd_t cmd,
	output logic      busy,
	output logic      done,
	output cdtb_rsp_t rsp
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	cdtb_ctl_t              ctl;
	cdtb_cmd_t              cmd_q;
	logic [AW-1:0]          addr;
	logic [WORD_W-1:0]      ctrl_rd;
	logic [WORD_W-1:0]      load_rd;
	logic [WORD_W-1:0]      stat_rd;
	logic [COUNT_WIDTH-1:0] count_rd;
	logic [NUM_TIMERS-1:0]  expired;
	logic [MASK_W-1:0]      mask;
	logic [WORD_W-1:0]      rd_val;
	logic                   done_q;
	cdtb_rsp_t              rsp_q;

	cdtb_seq #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.ctl   (ctl),
		.cmd_q (cmd_q),
		.addr  (addr)
	);

	cdtb_word_ram #(
		.DEPTH(NUM_TIMERS),
		.WIDTH(WORD_W)
	) u_ctrl_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ctl.bus_we && (cmd_q.field_select == FIELD_CONTROL)),
		.waddr (addr),
		.wdata (cmd_q.write_value),
		.re    (ctl.bus_re),
		.raddr (addr),
		.rdata (ctrl_rd)
	);

	cdtb_word_ram #(
		.DEPTH(NUM_TIMERS),
		.WIDTH(WORD_W)
	) u_load_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ctl.bus_we && (cmd_q.field_select == FIELD_LOAD)),
		.waddr (addr),
		.wdata (cmd_q.write_value),
		.re    (ctl.bus_re),
		.raddr (addr),
		.rdata (load_rd)
	);

	cdtb_word_ram #(
		.DEPTH(NUM_TIMERS),
		.WIDTH(WORD_W)
	) u_stat_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ctl.bus_we && (cmd_q.field_select == FIELD_STATUS)),
		.waddr (addr),
		.wdata (cmd_q.write_value),
		.re    (ctl.bus_re),
		.raddr (addr),
		.rdata (stat_rd)
	);

	cdtb_tick_unit #(
		.NUM_TIMERS (NUM_TIMERS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.addr    (addr),
		.cmd_q   (cmd_q),
		.count_rd(count_rd),
		.expired (expired)
	);

	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < NUM_TIMERS) begin : g_on
			assign mask[i] = expired[i];
		end else begin : g_off
			assign mask[i] = 1'b0;
		end
	end

	// expired bit lives in flops, the rest of the status word in memory
	always_comb begin
		rd_val = '0;
		if (ctl.hit && (cmd_q.mode == MODE_READ)) begin
			case (cmd_q.field_select)
				FIELD_CONTROL: rd_val = ctrl_rd;
				FIELD_LOAD: rd_val = load_rd;
				FIELD_COUNT: rd_val = WORD_W'(count_rd);
				FIELD_STATUS: rd_val = {stat_rd[WORD_W-1:1], expired[addr]};
				default: rd_val = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.resp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.resp) begin
			rsp_q.read_value <= rd_val;
			rsp_q.expired_mask <= mask;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	localparam logic [MASK_W-1:0] MASK_LIVE =
		(NUM_TIMERS >= MASK_W) ? '1 : MASK_W'((64'd1 << NUM_TIMERS) - 64'd1);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.expired_mask & ~MASK_LIVE) == '0))
		else $error("expired bit set for a timer that does not exist");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
`endif

endmodule

@@ tb/tb_countdown_timer_bank_top.sv @@
`default_nettype none

module tb_countdown_timer_bank_top;
	import cdtb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TIMERS = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 600;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [WORD_W-1:0] ENABLE_MASK = 32'h8000_0000;

	class timer_scoreboard;
		logic [WORD_W-1:0] ctrl_word [NUM_TIMERS];
		logic [WORD_W-1:0] load_word [NUM_TIMERS];
		logic [WORD_W-1:0] cnt_word [NUM_TIMERS];
		logic [WORD_W-1:0] stat_word [NUM_TIMERS];
		cdtb_rsp_t pending_rsp [$];
		int err_count;

		function new();
			for (int i = 0; i < NUM_TIMERS; i++) begin
				ctrl_word[i] = '0;
				load_word[i] = '0;
				cnt_word[i] = '0;
				stat_word[i] = '0;
			end
			err_count = 0;
		endfunction

		// applies one accepted item and queues the response it must produce
		function void note_item(cdtb_cmd_t c);
			cdtb_rsp_t r;
			r = '0;
			case (c.mode)
				MODE_TICK: begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (ctrl_word[i][ENABLE_BIT] && cnt_word[i] != '0) begin
							cnt_word[i] = cnt_word[i] - 1'b1;
							if (cnt_word[i] == '0)
								stat_word[i][EXPIRED_BIT] = 1'b1;
						end
					end
				end
				MODE_WRITE: begin
					case (c.field_select)
						FIELD_CONTROL: ctrl_word[c.timer_index] = c.write_value;
						FIELD_LOAD: load_word[c.timer_index] = c.write_value;
						FIELD_COUNT: cnt_word[c.timer_index] = c.write_value;
						default: stat_word[c.timer_index] = c.write_value;
					endcase
				end
				MODE_READ: begin
					case (c.field_select)
						FIELD_CONTROL: r.read_value = ctrl_word[c.timer_index];
						FIELD_LOAD: r.read_value = load_word[c.timer_index];
						FIELD_COUNT: r.read_value = cnt_word[c.timer_index];
						default: r.read_value = stat_word[c.timer_index];
					endcase
				end
				default: ;
			endcase
			for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++)
				r.expired_mask[i] = stat_word[i][EXPIRED_BIT];
			pending_rsp.push_back(r);
		endfunction

		function void check_result(cdtb_rsp_t got);
			cdtb_rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none, got read_value %h expired_mask %h",
					$time, got.read_value, got.expired_mask);
				err_count++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value mismatch, expected %h, got %h",
					$time, want.read_value, got.read_value);
				err_count++;
			end
			if (got.expired_mask !== want.expired_mask) begin
				$display("%0t: expired_mask mismatch, expected %h, got %h",
					$time, want.expired_mask, got.expired_mask);
				err_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	cdtb_cmd_t cmd;
	logic busy;
	logic done;
	cdtb_rsp_t rsp;

	timer_scoreboard sb;

	countdown_timer_bank_top #(
		.NUM_TIMERS(NUM_TIMERS),
		.COUNT_WIDTH(WORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// responses are checked before the item taken at the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(rsp);
			if (start && !busy)
				sb.note_item(cmd);
		end
	end

	function automatic cdtb_cmd_t make_cmd(logic [1:0] m, logic [IDX_W-1:0] idx,
		logic [1:0] sel, logic [WORD_W-1:0] val);
		cdtb_cmd_t c;
		c.mode = m;
		c.timer_index = idx;
		c.field_select = sel;
		c.write_value = val;
		return c;
	endfunction

	function automatic cdtb_cmd_t random_item();
		cdtb_cmd_t c;
		int pick;
		c.timer_index = IDX_W'($urandom_range(0, NUM_TIMERS - 1));
		c.field_select = 2'($urandom_range(0, 3));
		c.write_value = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c.mode = MODE_TICK;
		else if (pick < 75)
			c.mode = MODE_WRITE;
		else if (pick < 95)
			c.mode = MODE_READ;
		else
			c.mode = MODE_UNUSED;
		if (c.mode == MODE_WRITE) begin
			// small counts and mostly enabled timers so expiries happen often
			if (c.field_select == FIELD_CONTROL) begin
				if ($urandom_range(0, 99) < 70)
					c.write_value = c.write_value | ENABLE_MASK;
				else
					c.write_value = c.write_value & ~ENABLE_MASK;
			end else if (c.field_select == FIELD_COUNT && $urandom_range(0, 99) < 75) begin
				c.write_value = $urandom_range(0, 8);
			end
		end
		return c;
	endfunction

	task automatic send_item(input cdtb_cmd_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		cmd <= random_item();
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_pending();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_rsp.size() != 0) @(posedge clk);
	endtask

	initial begin
		cdtb_cmd_t directed [$];
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_cmd(MODE_READ, 5'd0, FIELD_CONTROL, 32'h0));
		directed.push_back(make_cmd(MODE_READ, 5'd31, FIELD_LOAD, 32'hFFFF_FFFF));
		directed.push_back(make_cmd(MODE_READ, 5'd5, FIELD_COUNT, 32'h0));
		directed.push_back(make_cmd(MODE_READ, 5'd31, FIELD_STATUS, 32'h0));
		directed.push_back(make_cmd(MODE_WRITE, 5'd0, FIELD_CONTROL, ENABLE_MASK));
		directed.push_back(make_cmd(MODE_WRITE, 5'd31, FIELD_CONTROL, 32'hFFFF_FFFF));
		directed.push_back(make_cmd(MODE_WRITE, 5'd0, FIELD_COUNT, 32'h1));
		directed.push_back(make_cmd(MODE_WRITE, 5'd31, FIELD_COUNT, 32'hFFFF_FFFF));
		directed.push_back(make_cmd(MODE_WRITE, 5'd7, FIELD_COUNT, 32'h2));
		directed.push_back(make_cmd(MODE_WRITE, 5'd3, FIELD_LOAD, 32'hFFFF_FFFF));
		directed.push_back(make_cmd(MODE_TICK, 5'd0, FIELD_CONTROL, 32'h0));
		directed.push_back(make_cmd(MODE_READ, 5'd0, FIELD_STATUS, 32'h0));
		directed.push_back(make_cmd(MODE_READ, 5'd31, FIELD_COUNT, 32'h0));
		directed.push_back(make_cmd(MODE_READ, 5'd7, FIELD_COUNT, 32'h0));
		// rewriting the count of an expired timer keeps its status
		directed.push_back(make_cmd(MODE_WRITE, 5'd0, FIELD_COUNT, 32'h3));
		directed.push_back(make_cmd(MODE_TICK, 5'd31, FIELD_STATUS, 32'hFFFF_FFFF));
		directed.push_back(make_cmd(MODE_READ, 5'd0, FIELD_STATUS, 32'h0));
		directed.push_back(make_cmd(MODE_WRITE, 5'd0, FIELD_STATUS, 32'h0));
		directed.push_back(make_cmd(MODE_WRITE, 5'd31, FIELD_COUNT, 32'h0));
		directed.push_back(make_cmd(MODE_TICK, 5'd0, FIELD_CONTROL, 32'h0));
		directed.push_back(make_cmd(MODE_UNUSED, 5'd31, FIELD_STATUS, 32'hFFFF_FFFF));
		directed.push_back(make_cmd(MODE_READ, 5'd3, FIELD_LOAD, 32'h0));
		directed.push_back(make_cmd(MODE_WRITE, 5'd0, FIELD_CONTROL, 32'h4000_0000));
		directed.push_back(make_cmd(MODE_TICK, 5'd0, FIELD_CONTROL, 32'h0));
		directed.push_back(make_cmd(MODE_READ, 5'd31, FIELD_CONTROL, 32'h0));

		foreach (directed[i])
			send_item(directed[i]);
		drain_pending();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain_pending();
			else if ((n < 350 || n >= 470) && $urandom_range(0, 99) < 28) begin
				if ($urandom_range(0, 3) == 0)
					idle_cycles($urandom_range(1, 40));
				else
					idle_cycles($urandom_range(1, 3));
			end
			send_item(random_item());
		end

		drain_pending();
		repeat (40) @(posedge clk);
		if (sb.err_count == 0 && sb.pending_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ countdown_timer_bank_top.f @@
rtl/cdtb_pkg.sv
rtl/cdtb_word_ram.sv
rtl/cdtb_tick_unit.sv
rtl/cdtb_seq.sv
rtl/countdown_timer_bank_top.sv
tb/tb_countdown_timer_bank_top.sv
